>>> rtl/kft_pkg.sv
// Package for the two-axis tilt filter: widths, reset values, register indexes,
// datapath opcodes, the per-axis micro-program and the saturation helper.
// No dependencies.
package kft_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_BITS    = 16;
    localparam int WINDOW_DEPTH = 8;    // power of two, mean is a shift
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int SUM_W        = DATA_W + SLOT_W + 1;
    localparam int CFG_W        = 24;
    localparam int DT_W         = 16;
    localparam int DIV_NUM_W    = DATA_W + FRAC_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_NUM_W + 1);
    localparam int PROG_LEN     = 30;
    localparam int PC_W         = $clog2(PROG_LEN);

    localparam logic signed [DATA_W-1:0] COV_INIT =
        DATA_W'(100 * (64'sd1 <<< FRAC_BITS));
    localparam logic [CFG_W-1:0] QA_INIT = CFG_W'(((64'd1 << FRAC_BITS) + 5) / 10);
    localparam logic [CFG_W-1:0] QB_INIT = CFG_W'(((64'd1 << FRAC_BITS) + 500) / 1000);
    localparam logic [CFG_W-1:0] RM_INIT = CFG_W'(((64'd1 << FRAC_BITS) + 5) / 10);

    localparam logic [1:0] CFG_Q_ANGLE   = 2'd0;
    localparam logic [1:0] CFG_Q_BIAS    = 2'd1;
    localparam logic [1:0] CFG_R_MEASURE = 2'd2;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

    typedef enum logic [4:0] {
        S_ANG, S_BIAS, S_P0, S_P1, S_P2, S_P3,
        S_T, S_U, S_V, S_Y, S_S, S_K0, S_K1, S_RATE,
        S_MEAS, S_GYRO, S_DT, S_QA, S_QB, S_RM
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t dst;
        sel_t a;
        sel_t b;
    } micro_t;

    typedef struct packed {
        logic   load;
        logic   issue;
        logic   win;
        logic   axis;
        micro_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
    } dp_stat_t;

    function automatic micro_t mk(input op_t op, input sel_t d, input sel_t a, input sel_t b);
        micro_t m;
        m.op  = op;
        m.dst = d;
        m.a   = a;
        m.b   = b;
        return m;
    endfunction

    // predict, then correct; U and V hold K1*P00 and K1*P01
    function automatic micro_t prog_step(input logic [PC_W-1:0] pc);
        micro_t m;
        case (pc)
            PC_W'(0):  m = mk(OP_SUB, S_RATE, S_GYRO, S_BIAS);
            PC_W'(1):  m = mk(OP_MUL, S_T,    S_DT,   S_RATE);
            PC_W'(2):  m = mk(OP_ADD, S_ANG,  S_ANG,  S_T);
            PC_W'(3):  m = mk(OP_MUL, S_T,    S_DT,   S_P3);
            PC_W'(4):  m = mk(OP_SUB, S_T,    S_T,    S_P1);
            PC_W'(5):  m = mk(OP_SUB, S_T,    S_T,    S_P2);
            PC_W'(6):  m = mk(OP_ADD, S_T,    S_T,    S_QA);
            PC_W'(7):  m = mk(OP_MUL, S_T,    S_DT,   S_T);
            PC_W'(8):  m = mk(OP_ADD, S_P0,   S_P0,   S_T);
            PC_W'(9):  m = mk(OP_MUL, S_T,    S_DT,   S_P3);
            PC_W'(10): m = mk(OP_SUB, S_P1,   S_P1,   S_T);
            PC_W'(11): m = mk(OP_SUB, S_P2,   S_P2,   S_T);
            PC_W'(12): m = mk(OP_MUL, S_T,    S_QB,   S_DT);
            PC_W'(13): m = mk(OP_ADD, S_P3,   S_P3,   S_T);
            PC_W'(14): m = mk(OP_SUB, S_Y,    S_MEAS, S_ANG);
            PC_W'(15): m = mk(OP_ADD, S_S,    S_P0,   S_RM);
            PC_W'(16): m = mk(OP_DIV, S_K0,   S_P0,   S_S);
            PC_W'(17): m = mk(OP_DIV, S_K1,   S_P2,   S_S);
            PC_W'(18): m = mk(OP_MUL, S_T,    S_K0,   S_Y);
            PC_W'(19): m = mk(OP_ADD, S_ANG,  S_ANG,  S_T);
            PC_W'(20): m = mk(OP_MUL, S_T,    S_K1,   S_Y);
            PC_W'(21): m = mk(OP_ADD, S_BIAS, S_BIAS, S_T);
            PC_W'(22): m = mk(OP_MUL, S_U,    S_K1,   S_P0);
            PC_W'(23): m = mk(OP_MUL, S_T,    S_K0,   S_P0);
            PC_W'(24): m = mk(OP_SUB, S_P0,   S_P0,   S_T);
            PC_W'(25): m = mk(OP_SUB, S_P2,   S_P2,   S_U);
            PC_W'(26): m = mk(OP_MUL, S_V,    S_K1,   S_P1);
            PC_W'(27): m = mk(OP_MUL, S_T,    S_K0,   S_P1);
            PC_W'(28): m = mk(OP_SUB, S_P1,   S_P1,   S_T);
            PC_W'(29): m = mk(OP_SUB, S_P3,   S_P3,   S_V);
            default:   m = mk(OP_ADD, S_T,    S_T,    S_T);
        endcase
        return m;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh7FFF_FFFF)
            r = {1'b0, {(DATA_W-1){1'b1}}};
        else if (v < -64'sh8000_0000)
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/kft_ctrl.sv
// Sequencer for the tilt filter: walks the micro-program once per axis,
// then updates the window and hands the result to the output register.
// Depends on kft_pkg.
module kft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output kft_pkg::dp_cmd_t  cmd,
    input  kft_pkg::dp_stat_t stat
);
    import kft_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_WIN   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              axis_reg, axis_next;
    logic              out_valid_reg, out_valid_next;
    micro_t            uop;
    logic              step_done;
    logic              out_free;

    assign uop       = prog_step(pc_reg);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        step_done = 1'b0;
        case (state_reg)
            ST_ISSUE: step_done = (uop.op == OP_ADD) || (uop.op == OP_SUB);
            ST_WAIT:  step_done = stat.done;
            default:  step_done = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                    pc_next    = '0;
                    axis_next  = 1'b0;
                end
            end
            ST_ISSUE:
            begin
                if (!step_done)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (step_done)
                    state_next = ST_ISSUE;
            end
            ST_WIN:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (step_done)
        begin
            if (pc_reg == PC_W'(PROG_LEN - 1))
            begin
                pc_next = '0;
                if (axis_reg)
                    state_next = ST_WIN;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            else
            begin
                pc_next    = pc_reg + PC_W'(1);
                state_next = ST_ISSUE;
            end
        end
    end

    always_comb
    begin
        cmd.load  = (state_reg == ST_IDLE) && in_valid;
        cmd.issue = (state_reg == ST_ISSUE);
        cmd.win   = (state_reg == ST_WIN) && out_free;
        cmd.axis  = axis_reg;
        cmd.uop   = uop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/kft_div.sv
// Radix-2 restoring divider for Q16.16 quotients, one bit per cycle,
// truncating toward zero and saturating; zero divisor gives zero.
// Depends on kft_pkg.
module kft_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [kft_pkg::DATA_W-1:0]  num,
    input  logic signed [kft_pkg::DATA_W-1:0]  den,
    output logic                               done,
    output logic signed [kft_pkg::DATA_W-1:0]  quo
);
    import kft_pkg::*;

    logic                    busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0]    acc_reg, acc_next;
    logic [DATA_W:0]         rem_reg, rem_next;
    logic [DATA_W-1:0]       dmag_reg, dmag_next;
    logic                    neg_reg, neg_next;
    logic                    dz_reg, dz_next;
    logic [DATA_W-1:0]       nmag;
    logic [DATA_W:0]         rem_sh;
    logic                    fits;

    assign nmag   = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    assign rem_sh = {rem_reg[DATA_W-1:0], acc_reg[DIV_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, dmag_reg};
    assign done   = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_NUM_W));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = {nmag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dmag_next = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
            dz_next   = (den == '0);
        end
        else if (done)
            busy_next = 1'b0;
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            acc_next = {acc_reg[DIV_NUM_W-2:0], fits};
            rem_next = fits ? rem_sh - {1'b0, dmag_reg} : rem_sh;
        end
    end

    always_comb
    begin
        if (dz_reg)
            quo = '0;
        else if (!neg_reg)
            quo = (acc_reg > DIV_NUM_W'(64'h7FFF_FFFF)) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                       : acc_reg[DATA_W-1:0];
        else
            quo = (acc_reg > DIV_NUM_W'(64'h8000_0000)) ? {1'b1, {(DATA_W-1){1'b0}}}
                                                       : -acc_reg[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        dz_reg   <= dz_next;
    end

endmodule

>>> rtl/kft_datapath.sv
// Datapath of the tilt filter: per-axis state, temporaries, saturating
// adder, registered multiplier, divider, averaging window and output registers.
// Depends on kft_pkg and kft_div.
module kft_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kft_pkg::dp_cmd_t                   cmd,
    output kft_pkg::dp_stat_t                  stat,
    input  logic [1:0]                         cfg_index,
    input  logic                               cfg_we,
    input  logic [kft_pkg::CFG_W-1:0]          cfg_data,
    input  logic signed [kft_pkg::DATA_W-1:0]  pitch_accel_angle,
    input  logic signed [kft_pkg::DATA_W-1:0]  pitch_gyro_rate,
    input  logic signed [kft_pkg::DATA_W-1:0]  roll_accel_angle,
    input  logic signed [kft_pkg::DATA_W-1:0]  roll_gyro_rate,
    input  logic [kft_pkg::DT_W-1:0]           step_time,
    output logic signed [kft_pkg::DATA_W-1:0]  pitch_filtered,
    output logic signed [kft_pkg::DATA_W-1:0]  roll_filtered
);
    import kft_pkg::*;

    logic [CFG_W-1:0]          qa_reg, qb_reg, rm_reg;
    logic signed [DATA_W-1:0]  ang_reg  [2];
    logic signed [DATA_W-1:0]  bias_reg [2];
    logic signed [DATA_W-1:0]  p_reg    [2][4];
    logic signed [DATA_W-1:0]  meas_reg [2];
    logic signed [DATA_W-1:0]  gyro_reg [2];
    logic [DT_W-1:0]           dt_reg;
    logic signed [DATA_W-1:0]  t_reg, u_reg, v_reg, y_reg, s_reg, k0_reg, k1_reg, rate_reg;
    logic signed [DATA_W-1:0]  win_reg [2][WINDOW_DEPTH];
    logic signed [SUM_W-1:0]   sum_reg [2];
    logic [SLOT_W-1:0]         slot_reg;
    logic signed [DATA_W-1:0]  pf_reg, rf_reg;

    logic signed [63:0]        prod_reg;
    logic                      mul_pend_reg;
    sel_t                      dst_reg;

    logic signed [DATA_W-1:0]  bank [32];
    logic signed [DATA_W-1:0]  opa, opb;
    logic signed [DATA_W-1:0]  alu_res, mul_res, div_res, wb_val;
    logic signed [63:0]        prod_sh;
    logic                      div_start, div_done;
    logic                      wb_en;
    sel_t                      wb_dst;
    logic signed [SUM_W-1:0]   sum_next [2];
    logic signed [DATA_W-1:0]  mean [2];
    logic                      ax;

    assign ax = cmd.axis;

    always_comb
    begin
        for (int i = 0; i < 32; i++)
            bank[i] = '0;
        bank[S_ANG]  = ang_reg[ax];
        bank[S_BIAS] = bias_reg[ax];
        bank[S_P0]   = p_reg[ax][0];
        bank[S_P1]   = p_reg[ax][1];
        bank[S_P2]   = p_reg[ax][2];
        bank[S_P3]   = p_reg[ax][3];
        bank[S_T]    = t_reg;
        bank[S_U]    = u_reg;
        bank[S_V]    = v_reg;
        bank[S_Y]    = y_reg;
        bank[S_S]    = s_reg;
        bank[S_K0]   = k0_reg;
        bank[S_K1]   = k1_reg;
        bank[S_RATE] = rate_reg;
        bank[S_MEAS] = meas_reg[ax];
        bank[S_GYRO] = gyro_reg[ax];
        bank[S_DT]   = DATA_W'(dt_reg);
        bank[S_QA]   = DATA_W'(qa_reg);
        bank[S_QB]   = DATA_W'(qb_reg);
        bank[S_RM]   = DATA_W'(rm_reg);
    end

    assign opa = bank[cmd.uop.a];
    assign opb = bank[cmd.uop.b];

    always_comb
    begin
        if (cmd.uop.op == OP_SUB)
            alu_res = sat32(64'(opa) - 64'(opb));
        else
            alu_res = sat32(64'(opa) + 64'(opb));
    end

    // arithmetic shift floors, matching round toward minus infinity
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign mul_res = sat32(prod_sh);

    assign div_start = cmd.issue && (cmd.uop.op == OP_DIV);

    kft_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .done  (div_done),
        .quo   (div_res)
    );

    assign stat.done = mul_pend_reg || div_done;

    always_comb
    begin
        wb_en  = 1'b0;
        wb_dst = dst_reg;
        wb_val = alu_res;
        if (mul_pend_reg)
        begin
            wb_en  = 1'b1;
            wb_val = mul_res;
        end
        else if (div_done)
        begin
            wb_en  = 1'b1;
            wb_val = div_res;
        end
        else if (cmd.issue && (cmd.uop.op == OP_ADD || cmd.uop.op == OP_SUB))
        begin
            wb_en  = 1'b1;
            wb_dst = cmd.uop.dst;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            dst_reg <= cmd.uop.dst;
        if (cmd.issue && cmd.uop.op == OP_MUL)
            prod_reg <= opa * opb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_pend_reg <= 1'b0;
        else
            mul_pend_reg <= cmd.issue && (cmd.uop.op == OP_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= QA_INIT;
            qb_reg <= QB_INIT;
            rm_reg <= RM_INIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_Q_ANGLE:   qa_reg <= cfg_data;
                CFG_Q_BIAS:    qb_reg <= cfg_data;
                CFG_R_MEASURE: rm_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                ang_reg[a]  <= '0;
                bias_reg[a] <= '0;
                p_reg[a][0] <= COV_INIT;
                p_reg[a][1] <= '0;
                p_reg[a][2] <= '0;
                p_reg[a][3] <= COV_INIT;
            end
        end
        else if (wb_en)
        begin
            case (wb_dst)
                S_ANG:   ang_reg[ax]  <= wb_val;
                S_BIAS:  bias_reg[ax] <= wb_val;
                S_P0:    p_reg[ax][0] <= wb_val;
                S_P1:    p_reg[ax][1] <= wb_val;
                S_P2:    p_reg[ax][2] <= wb_val;
                S_P3:    p_reg[ax][3] <= wb_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg[0] <= pitch_accel_angle;
            gyro_reg[0] <= pitch_gyro_rate;
            meas_reg[1] <= roll_accel_angle;
            gyro_reg[1] <= roll_gyro_rate;
            dt_reg      <= step_time;
        end
        if (wb_en)
        begin
            case (wb_dst)
                S_T:     t_reg    <= wb_val;
                S_U:     u_reg    <= wb_val;
                S_V:     v_reg    <= wb_val;
                S_Y:     y_reg    <= wb_val;
                S_S:     s_reg    <= wb_val;
                S_K0:    k0_reg   <= wb_val;
                S_K1:    k1_reg   <= wb_val;
                S_RATE:  rate_reg <= wb_val;
                default: ;
            endcase
        end
    end

    // running sum: add the new angle, drop the one it overwrites
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            sum_next[a] = sum_reg[a] + SUM_W'(ang_reg[a]) - SUM_W'(win_reg[a][slot_reg]);
            if (sum_next[a] < 0)
                mean[a] = DATA_W'((sum_next[a] + SUM_W'(WINDOW_DEPTH - 1)) >>> SLOT_W);
            else
                mean[a] = DATA_W'(sum_next[a] >>> SLOT_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            for (int a = 0; a < 2; a++)
            begin
                sum_reg[a] <= '0;
                for (int i = 0; i < WINDOW_DEPTH; i++)
                    win_reg[a][i] <= '0;
            end
        end
        else if (cmd.win)
        begin
            slot_reg <= (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
            for (int a = 0; a < 2; a++)
            begin
                sum_reg[a]           <= sum_next[a];
                win_reg[a][slot_reg] <= ang_reg[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win)
        begin
            pf_reg <= mean[0];
            rf_reg <= mean[1];
        end
    end

    assign pitch_filtered = pf_reg;
    assign roll_filtered  = rf_reg;

endmodule

>>> rtl/kalman_tilt_filter_two_axis.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+---------------------------------------------
// input     | in_valid / in_ready     | pitch/roll accel angle, gyro rate, step_time
// output    | out_valid / out_ready   | pitch_filtered, roll_filtered
// config    | cfg_we                  | cfg_index, cfg_data (q_angle, q_bias, r_measure)
//
// One request at a time. Each request runs the 30-step micro-program once per axis on one
// multiplier, one adder and the shared one-bit-per-cycle divider (two divisions per axis).
// A finished result waits in the output register; the next request is taken
// meanwhile, and its window update holds until that result is taken.
// Reset is asynchronous and clears state, covariances and window at once.
module kalman_tilt_filter_two_axis (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [kft_pkg::DATA_W-1:0]  pitch_accel_angle,
    input  logic signed [kft_pkg::DATA_W-1:0]  pitch_gyro_rate,
    input  logic signed [kft_pkg::DATA_W-1:0]  roll_accel_angle,
    input  logic signed [kft_pkg::DATA_W-1:0]  roll_gyro_rate,
    input  logic [kft_pkg::DT_W-1:0]           step_time,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [kft_pkg::DATA_W-1:0]  pitch_filtered,
    output logic signed [kft_pkg::DATA_W-1:0]  roll_filtered,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [kft_pkg::CFG_W-1:0]          cfg_data
);
    import kft_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    kft_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_index         (cfg_index),
        .cfg_we            (cfg_we),
        .cfg_data          (cfg_data),
        .pitch_accel_angle (pitch_accel_angle),
        .pitch_gyro_rate   (pitch_gyro_rate),
        .roll_accel_angle  (roll_accel_angle),
        .roll_gyro_rate    (roll_gyro_rate),
        .step_time         (step_time),
        .pitch_filtered    (pitch_filtered),
        .roll_filtered     (roll_filtered)
    );

endmodule

>>> rtl/kft_checker.sv
// Port-level checks for the tilt filter, bound to the top level.
// Depends on kft_pkg and kalman_tilt_filter_two_axis.
module kft_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [kft_pkg::DATA_W-1:0]  pitch_filtered,
    input logic signed [kft_pkg::DATA_W-1:0]  roll_filtered
);
    import kft_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pitch_filtered) && $stable(roll_filtered))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in work");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared right after request");

endmodule

bind kalman_tilt_filter_two_axis kft_checker u_kft_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pitch_filtered (pitch_filtered),
    .roll_filtered  (roll_filtered)
);
